// File: rtl/core/weqc_pkg.sv
// Shared types and constants of the window event queue.
package weqc_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int DATA_W = 304;

    typedef enum logic [1:0] {
        KIND_INPUT  = 2'd0,
        KIND_CLOSE  = 2'd1,
        KIND_RESIZE = 2'd2,
        KIND_POP    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_PUSHED        = 3'd0,
        ST_PUSHED_DROP   = 3'd1,
        ST_RESIZE_MERGED = 3'd2,
        ST_CLOSE_DUP     = 3'd3,
        ST_POP_EMPTY     = 3'd4,
        ST_POP_INPUT     = 3'd5,
        ST_POP_CLOSE     = 3'd6,
        ST_POP_RESIZE    = 3'd7
    } status_t;

    typedef struct packed {
        kind_t              kind;
        logic [63:0]        timestamp;
        logic [15:0]        dev_num;
        logic [15:0]        event_type;
        logic [31:0]        event_flags;
        logic [15:0]        event_code;
        logic signed [31:0] event_value;
        logic [31:0]        pos_x;
        logic [31:0]        pos_y;
        logic [15:0]        width;
        logic [15:0]        height;
        logic [31:0]        surf_bytes;
    } entry_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

endpackage

// File: rtl/core/weqc_cell.sv
// One queue cell: holds an entry, loads a new one or takes its neighbour's.
module weqc_cell (
    input  logic                clk,
    input  weqc_pkg::cell_ctrl_t ctrl,
    input  weqc_pkg::entry_t    new_entry,
    input  weqc_pkg::entry_t    neighbour,
    output weqc_pkg::entry_t    entry
);

    weqc_pkg::entry_t entry_reg;
    weqc_pkg::entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.load)
        begin
            entry_next = new_entry;
        end
        else if (ctrl.shift)
        begin
            entry_next = neighbour;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// File: rtl/core/window_event_queue_coalescing.sv
// Top level of the window event queue with drop-oldest overflow and coalescing.
//
// Items enter on the s_ channel: s_tuser carries the kind (push input event,
// push close request, push resize, pop oldest), s_tdata the payload. Every
// accepted item yields exactly one result item on the m_ channel: m_tuser
// carries the status, m_tdata the popped entry's fields (zero where unused).
// The queue is a row of cells with the oldest entry in cell 0; a pop or a
// push into a full queue shifts every cell one place towards cell 0.
// Close-request deduplication checks every occupied cell at once.
// Each item's result is registered and shows in the cycle after the item is
// accepted. One item is accepted per cycle while the result register is empty or
// being taken; while the receiver stalls a held result, s_tready stays low.
// Reset empties the queue and clears the control and configuration registers;
// stored entries are left as they are and cannot be seen again.
// Configuration writes (cfg_we, cfg_addr, cfg_data) are registered and must be
// made only while the block is idle; the block itself does not enforce this.
module window_event_queue_coalescing (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_addr,
    input  logic [31:0]                   cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // timestamp, dev_num, event_type, event_flags, event_code, event_value,
    // screen_x, screen_y, new_width, new_height, new_surf_bytes
    input  logic [weqc_pkg::DATA_W-1:0]   s_tdata,
    // kind
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_timestamp, out_dev_num, out_event_type, out_event_flags,
    // out_event_code, out_event_value, local_x, local_y, out_width,
    // out_height, out_surf_bytes
    output logic [weqc_pkg::DATA_W-1:0]   m_tdata,
    // status
    output logic [2:0]                    m_tuser
);

    localparam int D = weqc_pkg::QUEUE_DEPTH;

    logic signed [31:0] origin_x_reg;
    logic signed [31:0] origin_y_reg;
    logic [15:0]        offset_x_reg;
    logic [15:0]        offset_y_reg;

    logic [weqc_pkg::CNT_W-1:0] count_reg;
    logic [weqc_pkg::CNT_W-1:0] count_next;
    logic                        out_valid_reg;
    logic [weqc_pkg::DATA_W-1:0] out_data_reg;
    logic [weqc_pkg::DATA_W-1:0] out_data_next;
    weqc_pkg::status_t           out_status_reg;
    weqc_pkg::status_t           out_status_next;

    weqc_pkg::entry_t     cells [D];
    weqc_pkg::cell_ctrl_t ctrl [D];
    weqc_pkg::entry_t     new_entry;
    weqc_pkg::kind_t      kind;
    logic                 accept;
    logic                 full;
    logic                 dup_close;
    logic                 do_push;
    logic                 do_shift;
    logic                 do_merge;
    logic [weqc_pkg::IDX_W-1:0] load_idx;
    logic [weqc_pkg::IDX_W-1:0] last_idx;
    logic signed [33:0]   lx;
    logic signed [33:0]   ly;
    logic [31:0]          cx;
    logic [31:0]          cy;

    assign kind     = weqc_pkg::kind_t'(s_tuser);
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == weqc_pkg::CNT_W'(D));
    assign last_idx = weqc_pkg::IDX_W'(count_reg - weqc_pkg::CNT_W'(1));

    // Local pointer position, saturated to signed 32 bits
    assign lx = {{2{s_tdata[207]}}, s_tdata[207:176]} - {{2{origin_x_reg[31]}}, origin_x_reg}
              - {18'd0, offset_x_reg};
    assign ly = {{2{s_tdata[239]}}, s_tdata[239:208]} - {{2{origin_y_reg[31]}}, origin_y_reg}
              - {18'd0, offset_y_reg};

    always_comb
    begin
        if (lx < -34'sd2147483648)
            cx = 32'h8000_0000;
        else if (lx > 34'sd2147483647)
            cx = 32'h7FFF_FFFF;
        else
            cx = lx[31:0];
        if (ly < -34'sd2147483648)
            cy = 32'h8000_0000;
        else if (ly > 34'sd2147483647)
            cy = 32'h7FFF_FFFF;
        else
            cy = ly[31:0];
    end

    always_comb
    begin
        dup_close = 1'b0;
        for (int i = 0; i < D; i++)
        begin
            if ((weqc_pkg::CNT_W'(i) < count_reg) && (cells[i].kind == weqc_pkg::KIND_CLOSE))
                dup_close = 1'b1;
        end
    end

    always_comb
    begin
        new_entry             = '0;
        new_entry.kind        = kind;
        if (kind == weqc_pkg::KIND_INPUT)
        begin
            new_entry.timestamp   = s_tdata[63:0];
            new_entry.dev_num     = s_tdata[79:64];
            new_entry.event_type  = s_tdata[95:80];
            new_entry.event_flags = s_tdata[127:96];
            new_entry.event_code  = s_tdata[143:128];
            new_entry.event_value = s_tdata[175:144];
            new_entry.pos_x       = cx;
            new_entry.pos_y       = cy;
        end
        else if (kind == weqc_pkg::KIND_RESIZE)
        begin
            new_entry.width       = s_tdata[255:240];
            new_entry.height      = s_tdata[271:256];
            new_entry.surf_bytes  = s_tdata[303:272];
        end
    end

    always_comb
    begin
        do_push         = 1'b0;
        do_shift        = 1'b0;
        do_merge        = 1'b0;
        count_next      = count_reg;
        out_data_next   = '0;
        out_status_next = weqc_pkg::ST_PUSHED;
        unique case (kind)
            weqc_pkg::KIND_INPUT:
                do_push = 1'b1;
            weqc_pkg::KIND_CLOSE:
            begin
                if (dup_close)
                    out_status_next = weqc_pkg::ST_CLOSE_DUP;
                else
                    do_push = 1'b1;
            end
            weqc_pkg::KIND_RESIZE:
            begin
                if ((count_reg != '0) && (cells[last_idx].kind == weqc_pkg::KIND_RESIZE))
                begin
                    do_merge        = 1'b1;
                    out_status_next = weqc_pkg::ST_RESIZE_MERGED;
                end
                else
                    do_push = 1'b1;
            end
            weqc_pkg::KIND_POP:
            begin
                if (count_reg == '0)
                    out_status_next = weqc_pkg::ST_POP_EMPTY;
                else
                begin
                    do_shift   = 1'b1;
                    count_next = count_reg - weqc_pkg::CNT_W'(1);
                    unique case (cells[0].kind)
                        weqc_pkg::KIND_INPUT:
                        begin
                            out_status_next        = weqc_pkg::ST_POP_INPUT;
                            out_data_next[63:0]    = cells[0].timestamp;
                            out_data_next[79:64]   = cells[0].dev_num;
                            out_data_next[95:80]   = cells[0].event_type;
                            out_data_next[127:96]  = cells[0].event_flags;
                            out_data_next[143:128] = cells[0].event_code;
                            out_data_next[175:144] = cells[0].event_value;
                            out_data_next[207:176] = cells[0].pos_x;
                            out_data_next[239:208] = cells[0].pos_y;
                        end
                        weqc_pkg::KIND_RESIZE:
                        begin
                            out_status_next        = weqc_pkg::ST_POP_RESIZE;
                            out_data_next[255:240] = cells[0].width;
                            out_data_next[271:256] = cells[0].height;
                            out_data_next[303:272] = cells[0].surf_bytes;
                        end
                        default:
                            out_status_next = weqc_pkg::ST_POP_CLOSE;
                    endcase
                end
            end
        endcase
        if (do_push)
        begin
            if (full)
            begin
                // drop the oldest entry to make room
                do_shift        = 1'b1;
                out_status_next = weqc_pkg::ST_PUSHED_DROP;
            end
            else
                count_next = count_reg + weqc_pkg::CNT_W'(1);
        end
    end

    always_comb
    begin
        if (do_merge)
            load_idx = last_idx;
        else if (full)
            load_idx = weqc_pkg::IDX_W'(D - 1);
        else
            load_idx = count_reg[weqc_pkg::IDX_W-1:0];
        for (int i = 0; i < D; i++)
        begin
            ctrl[i].shift = accept && do_shift;
            ctrl[i].load  = accept && (do_push || do_merge)
                          && (load_idx == weqc_pkg::IDX_W'(i));
        end
    end

    for (genvar g = 0; g < D; g++)
    begin : gen_cell
        weqc_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl[g]),
            .new_entry (new_entry),
            .neighbour (cells[(g + 1 < D) ? g + 1 : g]),
            .entry     (cells[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            offset_x_reg   <= '0;
            offset_y_reg   <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= weqc_pkg::ST_PUSHED;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    2'd0: origin_x_reg <= cfg_data;
                    2'd1: origin_y_reg <= cfg_data;
                    2'd2: offset_x_reg <= cfg_data[15:0];
                    2'd3: offset_y_reg <= cfg_data[15:0];
                endcase
            end
            if (accept)
            begin
                count_reg      <= count_next;
                out_valid_reg  <= 1'b1;
                out_status_reg <= out_status_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

endmodule

// File: tb/window_event_queue_coalescing_test.sv
// Self-checking testbench for the window event queue with drop-oldest overflow and coalescing.
module window_event_queue_coalescing_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REG_ORIGIN_X = 0;
    localparam int REG_ORIGIN_Y = 1;
    localparam int REG_OFFSET_X = 2;
    localparam int REG_OFFSET_Y = 3;

    typedef struct packed {
        logic [31:0] new_surf_bytes;
        logic [15:0] new_height;
        logic [15:0] new_width;
        logic [31:0] screen_y;
        logic [31:0] screen_x;
        logic [31:0] event_value;
        logic [15:0] event_code;
        logic [31:0] event_flags;
        logic [15:0] event_type;
        logic [15:0] dev_num;
        logic [63:0] timestamp;
    } payload_t;

    typedef struct packed {
        logic [31:0] surf_bytes;
        logic [15:0] height;
        logic [15:0] width;
        logic [31:0] local_y;
        logic [31:0] local_x;
        logic [31:0] event_value;
        logic [15:0] event_code;
        logic [31:0] event_flags;
        logic [15:0] event_type;
        logic [15:0] dev_num;
        logic [63:0] timestamp;
    } popped_t;

    typedef struct packed {
        weqc_pkg::status_t status;
        popped_t data;
    } outcome_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_addr;
    logic [31:0] cfg_data;
    logic s_tvalid;
    logic s_tready;
    logic [weqc_pkg::DATA_W-1:0] s_tdata;
    logic [1:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [weqc_pkg::DATA_W-1:0] m_tdata;
    logic [2:0] m_tuser;

    window_event_queue_coalescing i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // shadow queue state
    logic signed [31:0] origin_x, origin_y;
    logic [15:0] offset_x, offset_y;
    weqc_pkg::entry_t ring [weqc_pkg::QUEUE_DEPTH];
    int head, tail, fill;

    outcome_t pending[$];
    int errors, item_count, result_count, drops, merges, dups, empties;
    int stall_mode;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("window_event_queue_coalescing_test: errors");
        $finish;
    end

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'h7fffffff;
        if (v < -64'sd2147483648)
            return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic outcome_t queue_step(weqc_pkg::kind_t kind, payload_t p);
        outcome_t o;
        weqc_pkg::entry_t e;
        logic dup;
        int last;
        o = '0;
        o.status = weqc_pkg::ST_PUSHED;
        if (kind == weqc_pkg::KIND_POP)
        begin
            if (fill == 0)
            begin
                o.status = weqc_pkg::ST_POP_EMPTY;
                return o;
            end
            e = ring[head];
            if (e.kind == weqc_pkg::KIND_INPUT)
            begin
                o.status = weqc_pkg::ST_POP_INPUT;
                o.data.timestamp = e.timestamp;
                o.data.dev_num = e.dev_num;
                o.data.event_type = e.event_type;
                o.data.event_flags = e.event_flags;
                o.data.event_code = e.event_code;
                o.data.event_value = e.event_value;
                o.data.local_x = e.pos_x;
                o.data.local_y = e.pos_y;
            end
            else if (e.kind == weqc_pkg::KIND_RESIZE)
            begin
                o.status = weqc_pkg::ST_POP_RESIZE;
                o.data.width = e.width;
                o.data.height = e.height;
                o.data.surf_bytes = e.surf_bytes;
            end
            else
                o.status = weqc_pkg::ST_POP_CLOSE;
            head = (head + 1) % weqc_pkg::QUEUE_DEPTH;
            fill--;
            return o;
        end
        if (kind == weqc_pkg::KIND_CLOSE)
        begin
            dup = 1'b0;
            for (int i = 0; i < fill; i++)
                if (ring[(head + i) % weqc_pkg::QUEUE_DEPTH].kind == weqc_pkg::KIND_CLOSE)
                    dup = 1'b1;
            if (dup)
            begin
                o.status = weqc_pkg::ST_CLOSE_DUP;
                return o;
            end
        end
        if (kind == weqc_pkg::KIND_RESIZE && fill != 0)
        begin
            last = (tail + weqc_pkg::QUEUE_DEPTH - 1) % weqc_pkg::QUEUE_DEPTH;
            if (ring[last].kind == weqc_pkg::KIND_RESIZE)
            begin
                ring[last].width = p.new_width;
                ring[last].height = p.new_height;
                ring[last].surf_bytes = p.new_surf_bytes;
                o.status = weqc_pkg::ST_RESIZE_MERGED;
                return o;
            end
        end
        e = '0;
        e.kind = kind;
        if (kind == weqc_pkg::KIND_INPUT)
        begin
            e.timestamp = p.timestamp;
            e.dev_num = p.dev_num;
            e.event_type = p.event_type;
            e.event_flags = p.event_flags;
            e.event_code = p.event_code;
            e.event_value = p.event_value;
            e.pos_x = clamp32(longint'($signed(p.screen_x)) - longint'(origin_x)
                              - longint'(offset_x));
            e.pos_y = clamp32(longint'($signed(p.screen_y)) - longint'(origin_y)
                              - longint'(offset_y));
        end
        else if (kind == weqc_pkg::KIND_RESIZE)
        begin
            e.width = p.new_width;
            e.height = p.new_height;
            e.surf_bytes = p.new_surf_bytes;
        end
        if (fill >= weqc_pkg::QUEUE_DEPTH)
        begin
            head = (head + 1) % weqc_pkg::QUEUE_DEPTH;
            fill--;
            o.status = weqc_pkg::ST_PUSHED_DROP;
        end
        ring[tail] = e;
        tail = (tail + 1) % weqc_pkg::QUEUE_DEPTH;
        fill++;
        return o;
    endfunction

    task automatic write_reg(int index, logic [31:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= index[1:0];
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (index)
            REG_ORIGIN_X: origin_x = value;
            REG_ORIGIN_Y: origin_y = value;
            REG_OFFSET_X: offset_x = value[15:0];
            default:      offset_y = value[15:0];
        endcase
    endtask

    task automatic drain();
        while (pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_window(logic [31:0] ox, logic [31:0] oy, logic [15:0] bx, logic [15:0] by);
        drain();
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_OFFSET_X, {16'h0, bx});
        write_reg(REG_OFFSET_Y, {16'h0, by});
    endtask

    // Send one item; the expectation is queued at the accepting edge.
    task automatic send_item(weqc_pkg::kind_t kind, payload_t p);
        @(posedge clk);
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= weqc_pkg::DATA_W'(p);
        do
            @(posedge clk);
        while (!s_tready);
        pending.push_back(queue_step(kind, p));
        item_count++;
        s_tvalid <= 1'b0;
    endtask

    function automatic payload_t random_payload();
        payload_t p;
        logic [319:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom};
        p = raw[303:0];
        case ($urandom_range(0, 3))
            0: p.screen_x = 32'h80000000 | $urandom_range(0, 15);
            1: p.screen_x = 32'h7ffffff0 | $urandom_range(0, 15);
            default: p.screen_x = $urandom_range(0, 4000) - 1000;
        endcase
        case ($urandom_range(0, 3))
            0: p.screen_y = 32'h80000000 | $urandom_range(0, 15);
            1: p.screen_y = 32'h7ffffff0 | $urandom_range(0, 15);
            default: p.screen_y = $urandom_range(0, 4000) - 1000;
        endcase
        return p;
    endfunction

    // Random gap after a burst, sender side.
    task automatic sender_gap(ref int burst);
        if (burst > 0)
            burst--;
        else
        begin
            burst = $urandom_range(1, 12);
            repeat ($urandom_range(0, 6)) @(posedge clk);
        end
    endtask

    task automatic test_directed();
        payload_t p;
        set_window(32'h0, 32'h0, 16'h0, 16'h0);
        send_item(weqc_pkg::KIND_POP, '0);
        p = '1;
        send_item(weqc_pkg::KIND_INPUT, p);
        p = '0;
        send_item(weqc_pkg::KIND_INPUT, p);
        send_item(weqc_pkg::KIND_CLOSE, random_payload());
        send_item(weqc_pkg::KIND_CLOSE, random_payload());
        send_item(weqc_pkg::KIND_RESIZE, '1);
        send_item(weqc_pkg::KIND_RESIZE, random_payload());
        repeat (5) send_item(weqc_pkg::KIND_POP, '0);
        // extreme window: x origin at max, y origin at min; the first pointer saturates x low and y high
        set_window(32'h7fffffff, 32'h80000000, 16'hffff, 16'hffff);
        p = '0;
        p.screen_x = 32'h80000000;
        p.screen_y = 32'h7fffffff;
        send_item(weqc_pkg::KIND_INPUT, p);
        p.screen_x = 32'h7fffffff;
        p.screen_y = 32'h80000000;
        send_item(weqc_pkg::KIND_INPUT, p);
        // mixed run of QUEUE_DEPTH + 2 items; duplicate closes keep the queue short of full
        for (int i = 0; i < weqc_pkg::QUEUE_DEPTH + 2; i++)
            send_item(weqc_pkg::kind_t'(i % 3), random_payload());
        repeat (3) send_item(weqc_pkg::KIND_POP, '0);
    endtask

    task automatic test_random(int count, int pop_weight);
        payload_t p;
        int burst;
        int r;
        weqc_pkg::kind_t k;
        burst = 0;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < pop_weight)
                k = weqc_pkg::KIND_POP;
            else if (r < pop_weight + 15)
                k = weqc_pkg::KIND_CLOSE;
            else if (r < pop_weight + 35)
                k = weqc_pkg::KIND_RESIZE;
            else
                k = weqc_pkg::KIND_INPUT;
            p = random_payload();
            send_item(k, p);
            sender_gap(burst);
        end
    endtask

    // Receiver stall pattern: switches between always ready and random stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if ($urandom_range(0, 63) == 0)
                stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        outcome_t exp_o;
        popped_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            result_count++;
            got = popped_t'(m_tdata);
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result item: status %0d", m_tuser);
            end
            else
            begin
                exp_o = pending.pop_front();
                case (exp_o.status)
                    weqc_pkg::ST_PUSHED_DROP:   drops++;
                    weqc_pkg::ST_RESIZE_MERGED: merges++;
                    weqc_pkg::ST_CLOSE_DUP:     dups++;
                    weqc_pkg::ST_POP_EMPTY:     empties++;
                    default: ;
                endcase
                if (m_tuser !== exp_o.status || got !== exp_o.data)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch at item %0d: status exp %0d got %0d, data exp %h got %h",
                                 result_count, exp_o.status, m_tuser, exp_o.data, got);
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        origin_x = 0;
        origin_y = 0;
        offset_x = 0;
        offset_y = 0;
        head = 0;
        tail = 0;
        fill = 0;
        errors = 0;
        item_count = 0;
        result_count = 0;
        drops = 0;
        merges = 0;
        dups = 0;
        empties = 0;
        stall_mode = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        set_window($urandom, $urandom, 16'($urandom), 16'($urandom));
        test_random(350, 20);
        set_window(32'h80000000, 32'h7fffffff, 16'h0, 16'hffff);
        test_random(350, 10);
        set_window($urandom_range(0, 2000), $urandom_range(0, 2000),
                   16'($urandom_range(0, 40)), 16'($urandom_range(0, 60)));
        test_random(330, 45);
        drain();

        $display("covered %0d items, %0d results: %0d drops, %0d resize merges,",
                 item_count, result_count, drops, merges);
        $display("%0d duplicate closes, %0d empty pops, over five window settings",
                 dups, empties);
        if (errors == 0)
            $display("window_event_queue_coalescing_test: clean");
        else
            $display("window_event_queue_coalescing_test: errors");
        $finish;
    end
endmodule

// File: files.f
rtl/core/weqc_pkg.sv
rtl/core/weqc_cell.sv
rtl/core/window_event_queue_coalescing.sv
tb/window_event_queue_coalescing_test.sv
